>>> hw/rtl/sxf_pkg.sv
// shared types and constants of the stx/etx frame receiver
`default_nettype none

package sxf_pkg;

   localparam logic [7:0]  STX_BYTE           = 8'h02;
   localparam logic [7:0]  ETX_BYTE           = 8'h03;
   localparam logic [7:0]  MIN_FRAME_BYTES    = 8'd4;
   // crc-16/arc: poly 0x8005 taken reflected, init 0x0000, no final xor
   localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA001;
   localparam logic [15:0] CRC_INIT           = 16'h0000;

   typedef enum logic [1:0] {
      SYNC_NONE   = 2'd0,
      SYNC_LOCKED = 2'd1,
      SYNC_FRAME  = 2'd2
   } sync_state_type;

   typedef enum logic [1:0] {
      EVENT_DATA   = 2'd0,
      EVENT_ACCEPT = 2'd1,
      EVENT_DROP   = 2'd2
   } event_kind_type;

   typedef enum logic {
      OP_BYTE      = 1'b0,
      OP_DROP_SYNC = 1'b1
   } operation_type;

   typedef struct packed {
      logic          advance;
      operation_type operation;
      logic [7:0]    rx_byte;
   } deframer_step_type;

   typedef struct packed {
      logic           valid;
      event_kind_type kind;
      logic [7:0]     payload_byte;
      logic [7:0]     frame_address;
      logic [7:0]     payload_length;
   } frame_result_type;

endpackage

`default_nettype wire

>>> hw/rtl/sxf_stream_if.sv
// valid/ready channel interfaces for received bytes and frame events
`default_nettype none

interface sxf_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] rx_byte;

   modport source (output valid, output operation, output rx_byte, input ready);
   modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface sxf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [7:0] payload_byte;
   logic [7:0] frame_address;
   logic [7:0] payload_length;

   modport source (output valid, output event_kind, output payload_byte,
                   output frame_address, output payload_length, input ready);
   modport sink   (input valid, input event_kind, input payload_byte,
                   input frame_address, input payload_length, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sxf_crc16.sv
// byte-wide crc-16/arc update
`default_nettype none

module sxf_crc16
   import sxf_pkg::*;
(
   input  wire logic [15:0] crc_in,
   input  wire logic [7:0]  data_in,
   output logic      [15:0] crc_out
);

   always_comb begin
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data_in};
      for (int i = 0; i < 8; i++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY_REFLECTED;
         end else begin
            crc = crc >> 1;
         end
      end
      crc_out = crc;
   end

endmodule

`default_nettype wire

>>> hw/rtl/sxf_deframer.sv
// sync state machine, frame counters and event decode
`default_nettype none

module sxf_deframer
   import sxf_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 255
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire deframer_step_type step,
   input  wire logic              crc_check_enable,
   output frame_result_type       result
);

   localparam logic [7:0] MaxSize = 8'(MAX_FRAME_BYTES);

   sync_state_type state_ff, state_in;
   logic [7:0]     count_ff, count_in;
   logic [7:0]     size_ff, size_in;
   logic [7:0]     address_ff, address_in;
   logic [15:0]    crc_ff, crc_in;
   logic [15:0]    checksum_ff, checksum_in;
   logic [15:0]    crc_next;

   logic       is_drop_op;
   logic       is_stx;
   logic       is_etx;
   logic       count_zero;
   logic       size_bad;
   logic       in_body;
   logic       at_address;
   logic       at_data;
   logic       frame_good;
   logic [7:0] b;

   sxf_crc16 u_crc (
      .crc_in  (crc_ff),
      .data_in (step.rx_byte),
      .crc_out (crc_next)
   );

   assign b          = step.rx_byte;
   assign is_drop_op = (step.operation == OP_DROP_SYNC);
   assign is_stx     = (b == STX_BYTE);
   assign is_etx     = (b == ETX_BYTE);
   assign count_zero = (count_ff == 8'd0);
   assign size_bad   = (b < MIN_FRAME_BYTES) || (b > MaxSize);
   assign in_body    = (count_ff < size_ff);
   assign at_address = (count_ff == 8'd1);
   // the last two body bytes are the checksum
   assign at_data    = (({1'b0, count_ff} + 9'd2) < {1'b0, size_ff});
   assign frame_good = (size_ff > MIN_FRAME_BYTES) &&
                       !(crc_check_enable && (crc_ff != checksum_ff));

   // next sync state
   always_comb begin
      state_in = state_ff;
      if (is_drop_op) begin
         state_in = SYNC_NONE;
      end else begin
         case (state_ff)
            SYNC_NONE: begin
               if (is_stx) begin
                  state_in = SYNC_FRAME;
               end else if (is_etx) begin
                  state_in = SYNC_LOCKED;
               end
            end
            SYNC_LOCKED: begin
               state_in = is_stx ? SYNC_FRAME : SYNC_NONE;
            end
            SYNC_FRAME: begin
               if (count_zero) begin
                  state_in = size_bad ? SYNC_NONE : SYNC_FRAME;
               end else if (in_body) begin
                  state_in = SYNC_FRAME;
               end else begin
                  state_in = is_etx ? SYNC_LOCKED : SYNC_NONE;
               end
            end
            default: begin
               state_in = SYNC_NONE;
            end
         endcase
      end
   end

   // event decode
   always_comb begin
      result                = '0;
      result.kind           = EVENT_DATA;
      if (state_ff == SYNC_FRAME) begin
         if (is_drop_op) begin
            result.valid = 1'b1;
            result.kind  = EVENT_DROP;
         end else if (count_zero) begin
            if (size_bad) begin
               result.valid = 1'b1;
               result.kind  = EVENT_DROP;
            end
         end else if (in_body) begin
            if (!at_address && at_data) begin
               result.valid        = 1'b1;
               result.kind         = EVENT_DATA;
               result.payload_byte = b;
            end
         end else if (is_etx && frame_good) begin
            result.valid          = 1'b1;
            result.kind           = EVENT_ACCEPT;
            result.frame_address  = address_ff;
            result.payload_length = size_ff - MIN_FRAME_BYTES;
         end else begin
            result.valid = 1'b1;
            result.kind  = EVENT_DROP;
         end
      end
   end

   // frame counters, address, crc and checksum
   always_comb begin
      count_in    = count_ff;
      size_in     = size_ff;
      address_in  = address_ff;
      crc_in      = crc_ff;
      checksum_in = checksum_ff;
      if (!is_drop_op) begin
         case (state_ff)
            SYNC_NONE, SYNC_LOCKED: begin
               if (is_stx) begin
                  count_in    = 8'd0;
                  crc_in      = CRC_INIT;
                  checksum_in = 16'h0000;
               end
            end
            SYNC_FRAME: begin
               if (count_zero) begin
                  size_in  = b;
                  count_in = 8'd1;
                  crc_in   = crc_next;
               end else if (in_body) begin
                  count_in = count_ff + 8'd1;
                  if (at_address) begin
                     address_in = b;
                     crc_in     = crc_next;
                  end else if (at_data) begin
                     crc_in = crc_next;
                  end else begin
                     checksum_in = {checksum_ff[7:0], b};
                  end
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SYNC_NONE;
         count_ff    <= 8'd0;
         size_ff     <= 8'd0;
         address_ff  <= 8'd0;
         crc_ff      <= CRC_INIT;
         checksum_ff <= 16'h0000;
      end else if (step.advance) begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         size_ff     <= size_in;
         address_ff  <= address_in;
         crc_ff      <= crc_in;
         checksum_ff <= checksum_in;
      end
   end

   a_size_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SYNC_FRAME && count_ff != 8'd0) |->
         (size_ff >= MIN_FRAME_BYTES && size_ff <= MaxSize))
      else $error("frame size out of range inside a frame");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SYNC_FRAME) |-> (count_ff <= size_ff || count_zero))
      else $error("frame byte count ran past the frame size");

   a_accept_locks: assert property (@(posedge clock) disable iff (reset)
      (step.advance && result.valid && result.kind == EVENT_ACCEPT) |=>
         (state_ff == SYNC_LOCKED))
      else $error("accepted frame did not leave the block synced");

   a_result_in_frame: assert property (@(posedge clock) disable iff (reset)
      (result.valid) |-> (state_ff == SYNC_FRAME))
      else $error("event raised outside a frame");

endmodule

`default_nettype wire

>>> hw/rtl/stx_etx_length_frame_receiver.sv
// top level of the stx/etx length-prefixed frame receiver
// an accepted item is held in the input register, then decoded into the result register,
//   from which its event is taken
// throughput: one item per cycle while no result waits on the sink, set by the single-pass decode and crc step
// a result waiting on the sink holds the decode; the input stalls once the input register is full
// reset: synchronous, active high; clears sync state, counters, crc and csr bit
`default_nettype none

module stx_etx_length_frame_receiver
   import sxf_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 255
)
(
   input  wire logic  clock,
   input  wire logic  reset,
   sxf_req_if.sink    req,
   sxf_rsp_if.source  rsp,
   input  wire logic  csr_wr_en,
   input  wire logic  csr_wr_data
);

   // input register
   logic          in_valid_ff;
   operation_type in_operation_ff;
   logic [7:0]    in_byte_ff;

   // result register
   logic           out_valid_ff, out_valid_in;
   event_kind_type out_kind_ff;
   logic [7:0]     out_payload_ff;
   logic [7:0]     out_address_ff;
   logic [7:0]     out_length_ff;

   // crc check enable, off after reset
   logic crc_check_enable_ff;

   logic              advance;
   deframer_step_type step;
   frame_result_type  result;

   // the held item is decoded once the result register has room for its event
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   assign step = {advance, in_operation_ff, in_byte_ff};

   sxf_deframer #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_deframer (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .crc_check_enable (crc_check_enable_ff),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_check_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         crc_check_enable_ff <= csr_wr_data;
      end
   end

   // input register loads whenever it is empty or being drained
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_operation_ff <= operation_type'(req.operation);
         in_byte_ff      <= req.rx_byte;
      end
   end

   // items that raise no event just leave the result register empty
   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      if (advance) begin
         out_valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         out_kind_ff    <= result.kind;
         out_payload_ff <= result.payload_byte;
         out_address_ff <= result.frame_address;
         out_length_ff  <= result.payload_length;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.event_kind     = out_kind_ff;
   assign rsp.payload_byte   = out_payload_ff;
   assign rsp.frame_address  = out_address_ff;
   assign rsp.payload_length = out_length_ff;

endmodule

`default_nettype wire

>>> tb/stx_etx_length_frame_receiver_test.sv
// self-checking testbench for the stx/etx length-prefixed frame receiver
`default_nettype none

module stx_etx_length_frame_receiver_test
   import sxf_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_LIMIT = 255;
   // percent of cycles in which each side holds back
   localparam int GAP_PERCENT = 37;

   // one byte (or sync drop) offered on the line side
   typedef struct packed {
      operation_type op;
      logic [7:0]    value;
   } line_item_type;

   // one frame event as the deframer should report it
   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     data;
      logic [7:0]     addr;
      logic [7:0]     len;
   } frame_event_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   sxf_req_if req_if ();
   sxf_rsp_if rsp_if ();

   stx_etx_length_frame_receiver #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // line items still to be offered, and frame events still to come back
   line_item_type   line_items[$];
   frame_event_type frame_events[$];

   // when set, neither side leaves gaps
   bit no_gaps = 1'b0;
   int mismatches = 0;
   int stim_count = 0;

   // deframer state as the testbench tracks it
   sync_state_type sync_now = SYNC_NONE;
   logic [7:0]     frame_pos = 8'd0;
   logic [7:0]     frame_size = 8'd0;
   logic [7:0]     frame_addr = 8'd0;
   logic [15:0]    crc_run = CRC_INIT;
   logic [15:0]    crc_rx = 16'h0000;
   bit             crc_check_on = 1'b0;

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // crc-16/arc, one byte, lsb first
   function automatic logic [15:0] crc16_arc_update(input logic [15:0] crc,
                                                    input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
      return c;
   endfunction

   task automatic post_event(input event_kind_type kind, input logic [7:0] data,
                             input logic [7:0] addr, input logic [7:0] len);
      frame_event_type ev;
      ev.kind = kind;
      ev.data = data;
      ev.addr = addr;
      ev.len  = len;
      frame_events.push_back(ev);
   endtask

   task automatic open_frame();
      sync_now  = SYNC_FRAME;
      frame_pos = 8'd0;
      crc_run   = CRC_INIT;
      crc_rx    = 16'h0000;
   endtask

   // advance the tracked deframer by one accepted line item
   task automatic deframe_step(input operation_type op, input logic [7:0] b);
      int pos;
      // line error or disable: only a frame in progress is reported
      if (op == OP_DROP_SYNC) begin
         if (sync_now == SYNC_FRAME)
            post_event(EVENT_DROP, 8'd0, 8'd0, 8'd0);
         sync_now = SYNC_NONE;
         return;
      end
      case (sync_now)
         SYNC_NONE: begin
            if (b == STX_BYTE)
               open_frame();
            else if (b == ETX_BYTE)
               sync_now = SYNC_LOCKED;
         end
         SYNC_LOCKED: begin
            if (b == STX_BYTE)
               open_frame();
            else
               sync_now = SYNC_NONE;
         end
         SYNC_FRAME: begin
            if (frame_pos == 8'd0) begin
               // size byte, checked right away
               frame_size = b;
               frame_pos  = 8'd1;
               crc_run    = crc16_arc_update(crc_run, b);
               if (b < MIN_FRAME_BYTES || int'(b) > FRAME_LIMIT) begin
                  sync_now = SYNC_NONE;
                  post_event(EVENT_DROP, 8'd0, 8'd0, 8'd0);
               end
            end else if (frame_pos < frame_size) begin
               pos       = int'(frame_pos);
               frame_pos = frame_pos + 8'd1;
               if (pos == 1) begin
                  frame_addr = b;
                  crc_run    = crc16_arc_update(crc_run, b);
               end else if (pos + 2 < int'(frame_size)) begin
                  // payload byte, streamed out at once
                  crc_run = crc16_arc_update(crc_run, b);
                  post_event(EVENT_DATA, b, 8'd0, 8'd0);
               end else begin
                  // checksum, high byte first
                  crc_rx = {crc_rx[7:0], b};
               end
            end else if (b != ETX_BYTE) begin
               // missing end marker
               sync_now = SYNC_NONE;
               post_event(EVENT_DROP, 8'd0, 8'd0, 8'd0);
            end else begin
               sync_now = SYNC_LOCKED;
               if (frame_size <= MIN_FRAME_BYTES)
                  post_event(EVENT_DROP, 8'd0, 8'd0, 8'd0);
               else if (crc_check_on && crc_run != crc_rx)
                  post_event(EVENT_DROP, 8'd0, 8'd0, 8'd0);
               else
                  post_event(EVENT_ACCEPT, 8'd0, frame_addr, frame_size - MIN_FRAME_BYTES);
            end
         end
         default: sync_now = SYNC_NONE;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // driver: offers queued line items, predicts on each accepted one
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      line_item_type head_item;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            deframe_step(operation_type'(req_if.operation), req_if.rx_byte);
         // valid stays up until taken; a new item or a gap only after that
         if (!req_if.valid || req_if.ready) begin
            if (line_items.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
               head_item = line_items.pop_front();
               req_if.valid     <= 1'b1;
               req_if.operation <= head_item.op;
               req_if.rx_byte   <= head_item.value;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: checks every accepted event against the oldest prediction
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch %0d at %0t: %s got %0d want %0d",
               mismatches, $time, what, got, want);
   endtask

   always @(posedge clock) begin
      frame_event_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (frame_events.size() == 0) begin
               report_mismatch("event with none pending, kind",
                               int'(rsp_if.event_kind), -1);
            end else begin
               want = frame_events.pop_front();
               if (rsp_if.event_kind !== want.kind)
                  report_mismatch("event_kind", int'(rsp_if.event_kind), int'(want.kind));
               if (rsp_if.payload_byte !== want.data)
                  report_mismatch("payload_byte", int'(rsp_if.payload_byte),
                                  int'(want.data));
               if (rsp_if.frame_address !== want.addr)
                  report_mismatch("frame_address", int'(rsp_if.frame_address),
                                  int'(want.addr));
               if (rsp_if.payload_length !== want.len)
                  report_mismatch("payload_length", int'(rsp_if.payload_length),
                                  int'(want.len));
            end
         end
         rsp_if.ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus building, called between clock edges
   // ---------------------------------------------------------------------
   task automatic push_item(input operation_type op, input logic [7:0] b);
      line_item_type it;
      it.op    = op;
      it.value = b;
      line_items.push_back(it);
      stim_count++;
   endtask

   // whole frame: stx, size, address, data, crc high/low, closing byte
   // fill below zero gives random data bytes
   task automatic queue_frame(input int size, input logic [7:0] addr, input bit bad_crc,
                              input logic [7:0] tail, input int fill);
      logic [15:0] crc;
      logic [7:0]  d;
      crc = crc16_arc_update(CRC_INIT, size[7:0]);
      crc = crc16_arc_update(crc, addr);
      push_item(OP_BYTE, STX_BYTE);
      push_item(OP_BYTE, size[7:0]);
      push_item(OP_BYTE, addr);
      for (int i = 0; i < size - 4; i++) begin
         d = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
         crc = crc16_arc_update(crc, d);
         push_item(OP_BYTE, d);
      end
      if (bad_crc)
         crc = crc ^ (16'h0001 << $urandom_range(15));
      push_item(OP_BYTE, crc[15:8]);
      push_item(OP_BYTE, crc[7:0]);
      push_item(OP_BYTE, tail);
   endtask

   // mostly good frames with random content, the rest broken frames and noise
   task automatic queue_random(input int n);
      int start;
      int pick;
      int size;
      int cut;
      int k;
      start = stim_count;
      while (stim_count - start < n) begin
         pick = $urandom_range(99);
         if (pick < 68) begin
            // a few frames at the largest sizes, most of them short
            size = ($urandom_range(99) < 2) ? $urandom_range(200, FRAME_LIMIT)
                                            : $urandom_range(4, 24);
            queue_frame(size, 8'($urandom_range(255)), $urandom_range(99) < 12,
                        ($urandom_range(99) < 6) ? 8'($urandom_range(255)) : ETX_BYTE, -1);
         end else if (pick < 76) begin
            // size byte too small
            push_item(OP_BYTE, STX_BYTE);
            push_item(OP_BYTE, 8'($urandom_range(3)));
         end else if (pick < 86) begin
            // frame cut short by a line error
            size = $urandom_range(5, 24);
            cut  = $urandom_range(size - 1);
            push_item(OP_BYTE, STX_BYTE);
            push_item(OP_BYTE, size[7:0]);
            for (int i = 0; i < cut; i++)
               push_item(OP_BYTE, 8'($urandom_range(255)));
            push_item(OP_DROP_SYNC, 8'($urandom_range(255)));
         end else if (pick < 94) begin
            // line noise, mostly ignored
            k = $urandom_range(1, 3);
            for (int i = 0; i < k; i++)
               push_item(OP_BYTE, 8'($urandom_range(255)));
         end else begin
            push_item(OP_DROP_SYNC, 8'($urandom_range(255)));
         end
      end
   endtask

   // sender holds until everything queued has gone and every event is back,
   // then waits on for items still in flight that give no event
   task automatic drain();
      do
         @(negedge clock);
      while (line_items.size() != 0 || req_if.valid || frame_events.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_crc_check(input bit enable);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= enable;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      crc_check_on = enable;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      req_if.valid     = 1'b0;
      req_if.operation = OP_BYTE;
      req_if.rx_byte   = 8'h00;
      rsp_if.ready     = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // crc check off after reset
      // no sync: stray byte ignored, etx locks, anything but stx unlocks
      push_item(OP_BYTE, 8'h55);
      push_item(OP_BYTE, ETX_BYTE);
      push_item(OP_BYTE, 8'h00);
      // sync drop outside a frame gives nothing
      push_item(OP_DROP_SYNC, 8'hFF);
      // size below the minimum
      push_item(OP_BYTE, STX_BYTE);
      push_item(OP_BYTE, 8'd3);
      // empty data, dropped at the end marker
      queue_frame(4, 8'hFF, 1'b0, ETX_BYTE, -1);
      // bad crc passes while the check is off
      queue_frame(5, 8'h00, 1'b1, ETX_BYTE, 255);
      // missing end marker
      queue_frame(5, 8'h80, 1'b0, 8'h00, 0);
      // line error in the middle of a frame
      push_item(OP_BYTE, STX_BYTE);
      push_item(OP_BYTE, 8'd9);
      push_item(OP_BYTE, 8'h12);
      push_item(OP_DROP_SYNC, 8'h00);
      queue_random(400);
      drain();

      // crc check on: mismatch dropped, good frame accepted
      write_crc_check(1'b1);
      queue_frame(6, 8'h5A, 1'b1, ETX_BYTE, -1);
      queue_frame(6, 8'hA5, 1'b0, ETX_BYTE, -1);
      queue_random(350);
      drain();

      // check off again, both sides without gaps for a long stretch
      write_crc_check(1'b0);
      no_gaps = 1'b1;
      queue_random(250);
      drain();
      no_gaps = 1'b0;

      // check on, largest frame first
      write_crc_check(1'b1);
      queue_frame(FRAME_LIMIT, 8'hC3, 1'b0, ETX_BYTE, -1);
      queue_random(150);
      drain();
      repeat (8) @(negedge clock);

      if (mismatches == 0 && frame_events.size() == 0) begin
         $display("stx_etx_length_frame_receiver_test: PASS");
      end else begin
         $display("stx_etx_length_frame_receiver_test: FAIL");
      end
      $finish;
   end

   // hang guard
   initial begin
      #3000000;
      $display("stx_etx_length_frame_receiver_test: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
